@@ rtl/core/blac_pkg.sv @@
// Shared constants and codes for the budgeted LRU asset cache.
// Depends on nothing; the core module refers to it by scoped names.
package blac_pkg;

    // Table geometry and eviction policy.
    localparam int TABLE_ENTRIES = 32;
    localparam int GRACE_FRAMES  = 2;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Field widths.
    localparam int HASH_W  = 32;
    localparam int BYTES_W = 32;
    localparam int FRAME_W = 32;
    localparam int TOTAL_W = 40;
    localparam int BUDGET_W = 12;
    localparam int MIB_SHIFT = 20;

    // Item function codes.
    localparam logic [1:0] FUNC_LOOKUP   = 2'd0;
    localparam logic [1:0] FUNC_COMPLETE = 2'd1;
    localparam logic [1:0] FUNC_NEWFRAME = 2'd2;
    localparam logic [1:0] FUNC_SETTLE   = 2'd3;

    // Entry states and lookup status codes.
    localparam logic [1:0] ST_MISSING  = 2'd0;
    localparam logic [1:0] ST_LOADING  = 2'd1;
    localparam logic [1:0] ST_RESIDENT = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_ANSWER = 2'd0;
    localparam logic [1:0] KIND_EVICT  = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

endpackage

@@ rtl/core/budgeted_lru_asset_cache.sv @@
// Budgeted LRU asset cache: a scanned table of asset entries under a byte budget.
// Lookup and completion: one entry read a cycle into the single compare unit, a decision state,
// then the output load; a new frame goes straight to the output load. Settle checks the budget
// and scans for each eviction result, then gives the done result once within budget or when no
// entry is eligible; a stalled result holds the block. New items are taken only after the last load.
// Reset (synchronous, active low) clears valid bits, frame, total, budget and control.
module budgeted_lru_asset_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_budget_mb,
    // Input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_asset_hash,
    input  logic        i_in_package,
    input  logic        i_load_ok,
    input  logic [31:0] i_asset_bytes,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [1:0]  o_lookup_status,
    output logic        o_request_load,
    output logic [31:0] o_evicted_hash,
    output logic [31:0] o_freed_bytes,
    output logic [39:0] o_total_resident,
    output logic        o_last
);

    localparam int IW = blac_pkg::IDX_W;
    localparam int CW = blac_pkg::CNT_W;
    localparam int N  = blac_pkg::TABLE_ENTRIES;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [N-1:0] r_valid;
    logic [31:0] r_frame;
    logic [39:0] r_total;
    logic [11:0] r_budget_mb;

    // Entry tables.
    logic [31:0] r_key_mem  [N];
    logic [1:0]  r_st_mem   [N];
    logic [31:0] r_last_mem [N];
    logic [31:0] r_size_mem [N];

    // Captured item.
    logic [1:0]  r_func;
    logic [31:0] r_hash;
    logic        r_pkg;
    logic        r_ok;
    logic [31:0] r_bytes;

    // Scan pipeline and results.
    logic [CW-1:0] r_scan_cnt;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [31:0]   r_rd_key;
    logic [1:0]    r_rd_st;
    logic [31:0]   r_rd_last;
    logic [31:0]   r_rd_size;
    logic          r_found;
    logic [IW-1:0] r_match_idx;
    logic [1:0]    r_match_st;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic          r_best_found;
    logic [IW-1:0] r_best_idx;
    logic [31:0]   r_best_last;
    logic [31:0]   r_best_key;
    logic [31:0]   r_best_size;

    // Pending result.
    logic [1:0] r_p_kind;
    logic [1:0] r_p_status;
    logic       r_p_req;
    logic       r_p_last;

    // Output register.
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [1:0]  r_out_status;
    logic        r_out_req;
    logic [31:0] r_out_hash;
    logic [31:0] r_out_freed;
    logic [39:0] r_out_total;
    logic        r_out_last;

    logic          in_acc;
    logic          out_free;
    logic          emit_go;
    logic          issue;
    logic [IW-1:0] rd_addr;
    logic          scan_last;
    logic          ent_valid;
    logic          key_hit;
    logic          eligible;
    logic          older;
    logic [39:0]   limit;
    logic          over_budget;
    logic          start_scan;

    // Table write port and decision results.
    logic          we_key, we_st, we_last, we_size;
    logic [IW-1:0] wr_idx;
    logic [1:0]    wr_st;
    logic [31:0]   wr_size;
    logic [1:0]    d_kind;
    logic [1:0]    d_status;
    logic          d_req;
    logic          d_last;

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit_go     = (r_state == S_EMIT) && out_free;

    // Scan address issue: one entry read per cycle.
    assign issue     = (r_state == S_SCAN) && (r_scan_cnt != CW'(N));
    assign rd_addr   = r_scan_cnt[IW-1:0];
    assign scan_last = r_rd_vld && (r_rd_idx == IW'(N - 1));

    // Shared compare unit on the entry read last cycle.
    assign ent_valid = r_valid[r_rd_idx];
    assign key_hit   = ent_valid && (r_rd_key == r_hash);
    assign eligible  = ent_valid && (r_rd_st == blac_pkg::ST_RESIDENT) &&
                       (({1'b0, r_rd_last} + 33'(blac_pkg::GRACE_FRAMES)) <= {1'b0, r_frame});
    assign older     = !r_best_found || (r_rd_last < r_best_last);

    // Budget in bytes and its check.
    assign limit       = {8'd0, r_budget_mb, 20'd0};
    assign over_budget = (r_budget_mb != 12'd0) && (r_total > limit);
    assign start_scan  = (in_acc && (i_func == blac_pkg::FUNC_LOOKUP ||
                                     i_func == blac_pkg::FUNC_COMPLETE)) ||
                         (r_state == S_CHECK && over_budget);

    // Next sequencer state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_func)
                        blac_pkg::FUNC_LOOKUP:   n_state = S_SCAN;
                        blac_pkg::FUNC_COMPLETE: n_state = S_SCAN;
                        blac_pkg::FUNC_NEWFRAME: n_state = S_EMIT;
                        blac_pkg::FUNC_SETTLE:   n_state = S_CHECK;
                    endcase
                end
            end
            S_CHECK:  n_state = over_budget ? S_SCAN : S_EMIT;
            S_SCAN:   n_state = scan_last ? S_DECIDE : S_SCAN;
            S_DECIDE: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = (r_p_kind == blac_pkg::KIND_EVICT) ? S_CHECK : S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Decision after a scan: table writes and the pending result.
    always_comb begin
        we_key   = 1'b0;
        we_st    = 1'b0;
        we_last  = 1'b0;
        we_size  = 1'b0;
        wr_idx   = r_match_idx;
        wr_st    = blac_pkg::ST_MISSING;
        wr_size  = 32'd0;
        d_kind   = blac_pkg::KIND_ANSWER;
        d_status = blac_pkg::ST_MISSING;
        d_req    = 1'b0;
        d_last   = 1'b1;
        unique case (r_func)
            blac_pkg::FUNC_LOOKUP: begin
                if (r_hash != 32'd0) begin
                    if (r_found) begin
                        we_last  = (r_match_st == blac_pkg::ST_RESIDENT);
                        d_status = r_match_st;
                    end else if (r_free_found) begin
                        we_key   = 1'b1;
                        we_st    = 1'b1;
                        we_last  = 1'b1;
                        we_size  = 1'b1;
                        wr_idx   = r_free_idx;
                        wr_st    = r_pkg ? blac_pkg::ST_LOADING : blac_pkg::ST_MISSING;
                        d_status = wr_st;
                        d_req    = r_pkg;
                    end else begin
                        d_status = blac_pkg::ST_FULL;
                    end
                end
            end
            blac_pkg::FUNC_COMPLETE: begin
                if (r_found) begin
                    d_status = r_match_st;
                    if (r_match_st == blac_pkg::ST_LOADING) begin
                        we_st    = 1'b1;
                        we_last  = r_ok;
                        we_size  = r_ok;
                        wr_st    = r_ok ? blac_pkg::ST_RESIDENT : blac_pkg::ST_MISSING;
                        wr_size  = r_bytes;
                        d_status = wr_st;
                    end
                end
            end
            blac_pkg::FUNC_NEWFRAME: begin
                d_status = blac_pkg::ST_MISSING;
            end
            blac_pkg::FUNC_SETTLE: begin
                d_kind = r_best_found ? blac_pkg::KIND_EVICT : blac_pkg::KIND_DONE;
                d_last = !r_best_found;
            end
        endcase
    end

    // Entry tables: one write and one scan read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE) begin
            if (we_key) begin
                r_key_mem[wr_idx] <= r_hash;
            end
            if (we_st) begin
                r_st_mem[wr_idx] <= wr_st;
            end
            if (we_last) begin
                r_last_mem[wr_idx] <= r_frame;
            end
            if (we_size) begin
                r_size_mem[wr_idx] <= wr_size;
            end
        end
        if (issue) begin
            r_rd_key  <= r_key_mem[rd_addr];
            r_rd_st   <= r_st_mem[rd_addr];
            r_rd_last <= r_last_mem[rd_addr];
            r_rd_size <= r_size_mem[rd_addr];
        end
        r_rd_idx <= rd_addr;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_frame      <= 32'd0;
            r_total      <= 40'd0;
            r_budget_mb  <= 12'd0;
            r_scan_cnt   <= '0;
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (i_cfg_valid) begin
                r_budget_mb <= i_cfg_budget_mb;
            end
            if (in_acc && i_func == blac_pkg::FUNC_NEWFRAME) begin
                r_frame <= r_frame + 32'd1;
            end

            // Scan bookkeeping.
            if (start_scan) begin
                r_scan_cnt   <= '0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
                r_best_found <= 1'b0;
            end else begin
                if (issue) begin
                    r_scan_cnt <= r_scan_cnt + CW'(1);
                end
                if (r_rd_vld) begin
                    if (key_hit && !r_found) begin
                        r_found <= 1'b1;
                    end
                    if (!ent_valid && !r_free_found) begin
                        r_free_found <= 1'b1;
                    end
                    if (eligible && older) begin
                        r_best_found <= 1'b1;
                    end
                end
            end

            // Table updates at decision time.
            if (r_state == S_DECIDE) begin
                if (r_func == blac_pkg::FUNC_LOOKUP && we_key) begin
                    r_valid[wr_idx] <= 1'b1;
                end
                if (r_func == blac_pkg::FUNC_COMPLETE && we_size) begin
                    r_total <= r_total + {8'd0, r_bytes};
                end
                if (r_func == blac_pkg::FUNC_SETTLE && r_best_found) begin
                    r_valid[r_best_idx] <= 1'b0;
                    r_total <= (r_total >= {8'd0, r_best_size}) ?
                               r_total - {8'd0, r_best_size} : 40'd0;
                end
            end

            // Output register valid.
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: captured item, scan captures, pending and output result.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func  <= i_func;
            r_hash  <= i_asset_hash;
            r_pkg   <= i_in_package;
            r_ok    <= i_load_ok;
            r_bytes <= i_asset_bytes;
        end
        if (r_rd_vld) begin
            if (key_hit && !r_found) begin
                r_match_idx <= r_rd_idx;
                r_match_st  <= r_rd_st;
            end
            if (!ent_valid && !r_free_found) begin
                r_free_idx <= r_rd_idx;
            end
            if (eligible && older) begin
                r_best_idx  <= r_rd_idx;
                r_best_last <= r_rd_last;
                r_best_key  <= r_rd_key;
                r_best_size <= r_rd_size;
            end
        end

        // Pending result for the emit state.
        if (in_acc && i_func == blac_pkg::FUNC_NEWFRAME) begin
            r_p_kind   <= blac_pkg::KIND_ANSWER;
            r_p_status <= blac_pkg::ST_MISSING;
            r_p_req    <= 1'b0;
            r_p_last   <= 1'b1;
        end else if (r_state == S_CHECK && !over_budget) begin
            r_p_kind   <= blac_pkg::KIND_DONE;
            r_p_status <= blac_pkg::ST_MISSING;
            r_p_req    <= 1'b0;
            r_p_last   <= 1'b1;
        end else if (r_state == S_DECIDE) begin
            r_p_kind   <= d_kind;
            r_p_status <= d_status;
            r_p_req    <= d_req;
            r_p_last   <= d_last;
        end

        // Load the output register.
        if (emit_go) begin
            r_out_kind   <= r_p_kind;
            r_out_status <= r_p_status;
            r_out_req    <= r_p_req;
            r_out_hash   <= (r_p_kind == blac_pkg::KIND_EVICT) ? r_best_key : 32'd0;
            r_out_freed  <= (r_p_kind == blac_pkg::KIND_EVICT) ? r_best_size : 32'd0;
            r_out_total  <= r_total;
            r_out_last   <= r_p_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out_kind;
    assign o_lookup_status  = r_out_status;
    assign o_request_load   = r_out_req;
    assign o_evicted_hash   = r_out_hash;
    assign o_freed_bytes    = r_out_freed;
    assign o_total_resident = r_out_total;
    assign o_last           = r_out_last;

    // An eviction report is never the final result of a settle.
    a_evict_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == blac_pkg::KIND_EVICT) |-> !o_last)
        else $error("eviction report marked as last");

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a transfer");

    // The resident total never grows while a settle is in work.
    a_settle_no_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_func == blac_pkg::FUNC_SETTLE) |=> (r_total <= $past(r_total)))
        else $error("resident total grew during settle");

endmodule

@@ dv/tb_budgeted_lru_asset_cache.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for budgeted_lru_asset_cache: directed table, then random traffic.
// Depends on blac_pkg and the budgeted_lru_asset_cache RTL; nothing else.
module tb_budgeted_lru_asset_cache;

    localparam int N_ENT          = blac_pkg::TABLE_ENTRIES;
    localparam int NUM_DIRECTED   = 24;
    localparam int PHASE_ITEMS    = 39;
    localparam int KEY_POOL_SIZE  = 48;
    localparam int HOLD_CYCLES    = 300;
    localparam int ITEM_LATENCY   = N_ENT + 4;
    // Longest quiet stretch of a correct run is the long hold-off plus a few evictions.
    localparam int QUIET_LIMIT    = HOLD_CYCLES + 60 * ITEM_LATENCY;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] hash;
        logic        pkg;
        logic        ok;
        logic [31:0] bytes;
    } t_cache_op;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic        req;
        logic [31:0] hash;
        logic [31:0] freed;
        logic [39:0] total;
        logic        last;
    } t_cache_result;

    typedef struct packed {
        logic          cfg_first;
        logic [11:0]   cfg_value;
        t_cache_op     op;
        logic          typed;
        t_cache_result want;
    } t_stim_row;

    localparam t_cache_result UNTYPED = '0;

    // Clock, reset and the signals around the block.
    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_budget_mb;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] asset_hash;
    logic        in_package;
    logic        load_ok;
    logic [31:0] asset_bytes;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  res_kind;
    logic [1:0]  res_status;
    logic        res_req;
    logic [31:0] res_evicted_hash;
    logic [31:0] res_freed;
    logic [39:0] res_total;
    logic        res_last;

    // Predictor copy of the cache table and its configuration.
    logic        ent_valid    [N_ENT];
    logic [31:0] ent_key      [N_ENT];
    logic [1:0]  ent_state    [N_ENT];
    logic [31:0] ent_last_use [N_ENT];
    logic [31:0] ent_size     [N_ENT];
    logic [31:0] frame_now;
    logic [39:0] resident_bytes;
    logic [11:0] budget_now;

    t_cache_result item_replies [$];
    t_cache_result replies_due  [$];
    logic [31:0]   key_pool     [KEY_POOL_SIZE];

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_left;
    bit hold_request;
    int error_count;
    int reply_count;
    int quiet_cycles;

    // Directed rows: extremes, grace period, budget zero, ties and completion corner cases.
    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{1'b0, 12'd0, '{blac_pkg::FUNC_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
          1'b1, '{blac_pkg::KIND_ANSWER, blac_pkg::ST_MISSING, 1'b0, 32'h0, 32'h0,
                  40'h0, 1'b1}},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
          1'b1, '{blac_pkg::KIND_ANSWER, blac_pkg::ST_LOADING, 1'b1, 32'h0, 32'h0,
                  40'h0, 1'b1}},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_LOOKUP, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
          1'b1, '{blac_pkg::KIND_ANSWER, blac_pkg::ST_MISSING, 1'b0, 32'h0, 32'h0,
                  40'h0, 1'b1}},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_LOOKUP, 32'h0000_0001, 1'b1, 1'b1, 32'h0},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_COMPLETE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
          1'b1, '{blac_pkg::KIND_ANSWER, blac_pkg::ST_RESIDENT, 1'b0, 32'h0, 32'h0,
                  40'h00_FFFF_FFFF, 1'b1}},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_COMPLETE, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h5},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_COMPLETE, 32'h1234_5678, 1'b0, 1'b1, 32'h100},
          1'b1, '{blac_pkg::KIND_ANSWER, blac_pkg::ST_MISSING, 1'b0, 32'h0, 32'h0,
                  40'h00_FFFF_FFFF, 1'b1}},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_COMPLETE, 32'h0000_0001, 1'b0, 1'b1, 32'h7FFF_FFFF},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_LOOKUP, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_COMPLETE, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_FFFF},
          1'b1, '{blac_pkg::KIND_ANSWER, blac_pkg::ST_MISSING, 1'b0, 32'h0, 32'h0,
                  40'h00_FFFF_FFFF, 1'b1}},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_LOOKUP, 32'h5A5A_5A5A, 1'b1, 1'b0, 32'h0},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_COMPLETE, 32'h5A5A_5A5A, 1'b0, 1'b1, 32'h0010_0000},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_SETTLE, 32'hA5A5_A5A5, 1'b1, 1'b1, 32'hFFFF_FFFF},
          1'b1, '{blac_pkg::KIND_DONE, blac_pkg::ST_MISSING, 1'b0, 32'h0, 32'h0,
                  40'h01_000F_FFFF, 1'b1}},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_NEWFRAME, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
          1'b1, '{blac_pkg::KIND_ANSWER, blac_pkg::ST_MISSING, 1'b0, 32'h0, 32'h0,
                  40'h01_000F_FFFF, 1'b1}},
        '{1'b1, 12'hFFF, '{blac_pkg::FUNC_SETTLE, 32'h0, 1'b0, 1'b0, 32'h0},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_NEWFRAME, 32'h0, 1'b0, 1'b0, 32'h0},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_LOOKUP, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_SETTLE, 32'h0, 1'b0, 1'b0, 32'h0},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_LOOKUP, 32'h00C0_FFEE, 1'b1, 1'b0, 32'h0},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_COMPLETE, 32'h00C0_FFEE, 1'b1, 1'b1, 32'h0008_0000},
          1'b0, UNTYPED},
        '{1'b1, 12'd1, '{blac_pkg::FUNC_NEWFRAME, 32'h0, 1'b0, 1'b0, 32'h0},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_NEWFRAME, 32'h0, 1'b0, 1'b0, 32'h0},
          1'b0, UNTYPED},
        '{1'b0, 12'd0, '{blac_pkg::FUNC_SETTLE, 32'h0, 1'b0, 1'b0, 32'h0},
          1'b0, UNTYPED}
    };

    budgeted_lru_asset_cache dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_budget_mb  (cfg_budget_mb),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_func           (func),
        .i_asset_hash     (asset_hash),
        .i_in_package     (in_package),
        .i_load_ok        (load_ok),
        .i_asset_bytes    (asset_bytes),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_result_kind    (res_kind),
        .o_lookup_status  (res_status),
        .o_request_load   (res_req),
        .o_evicted_hash   (res_evicted_hash),
        .o_freed_bytes    (res_freed),
        .o_total_resident (res_total),
        .o_last           (res_last)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic note_mismatch(input string msg);
        error_count++;
        $display("%0t ERROR: %s", $realtime, msg);
    endtask

    // Queues one predicted reply, carrying the resident total as it stands now.
    function automatic void add_reply(input logic [1:0] kind, input logic [1:0] status,
                                      input logic req, input logic [31:0] hash,
                                      input logic [31:0] freed, input logic last);
        t_cache_result r;
        r.kind   = kind;
        r.status = status;
        r.req    = req;
        r.hash   = hash;
        r.freed  = freed;
        r.total  = resident_bytes;
        r.last   = last;
        item_replies.insert(item_replies.size(), r);
    endfunction

    function automatic int find_entry(input logic [31:0] key);
        for (int i = 0; i < N_ENT; i++) begin
            if (ent_valid[i] && ent_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Works out the replies of one item and advances the predicted table.
    task automatic predict_cache_replies(input t_cache_op op);
        int          idx;
        int          best;
        int          evicted;
        logic [1:0]  status;
        logic        req;
        logic [63:0] limit;
        logic [31:0] freed;
        item_replies.delete();
        status = blac_pkg::ST_MISSING;
        req    = 1'b0;
        case (op.func)
            blac_pkg::FUNC_LOOKUP: begin
                if (op.hash != '0) begin
                    idx = find_entry(op.hash);
                    if (idx < 0) begin
                        idx = 0;
                        while (idx < N_ENT && ent_valid[idx]) begin
                            idx++;
                        end
                        // No free slot: answer table full and leave everything alone.
                        if (idx == N_ENT) begin
                            add_reply(blac_pkg::KIND_ANSWER, blac_pkg::ST_FULL, 1'b0, '0, '0,
                                      1'b1);
                            return;
                        end
                        ent_valid[idx]    = 1'b1;
                        ent_key[idx]      = op.hash;
                        ent_state[idx]    = op.pkg ? blac_pkg::ST_LOADING : blac_pkg::ST_MISSING;
                        ent_last_use[idx] = frame_now;
                        ent_size[idx]     = '0;
                        req               = op.pkg;
                    end
                    if (ent_state[idx] == blac_pkg::ST_RESIDENT) begin
                        ent_last_use[idx] = frame_now;
                    end
                    status = ent_state[idx];
                end
                add_reply(blac_pkg::KIND_ANSWER, status, req, '0, '0, 1'b1);
            end
            blac_pkg::FUNC_COMPLETE: begin
                idx = find_entry(op.hash);
                if (idx >= 0) begin
                    if (ent_state[idx] == blac_pkg::ST_LOADING) begin
                        if (op.ok) begin
                            ent_state[idx]    = blac_pkg::ST_RESIDENT;
                            ent_size[idx]     = op.bytes;
                            ent_last_use[idx] = frame_now;
                            resident_bytes    = resident_bytes + 40'(op.bytes);
                        end else begin
                            ent_state[idx] = blac_pkg::ST_MISSING;
                        end
                    end
                    status = ent_state[idx];
                end
                add_reply(blac_pkg::KIND_ANSWER, status, 1'b0, '0, '0, 1'b1);
            end
            blac_pkg::FUNC_NEWFRAME: begin
                frame_now = frame_now + 32'd1;
                add_reply(blac_pkg::KIND_ANSWER, blac_pkg::ST_MISSING, 1'b0, '0, '0, 1'b1);
            end
            default: begin
                // Evict the oldest resident entry past its grace period until within budget.
                limit   = 64'(budget_now) << blac_pkg::MIB_SHIFT;
                evicted = 0;
                while (budget_now != '0 && 64'(resident_bytes) > limit
                       && evicted < N_ENT) begin
                    best = -1;
                    for (int i = 0; i < N_ENT; i++) begin
                        if (ent_valid[i] && ent_state[i] == blac_pkg::ST_RESIDENT
                            && 64'(ent_last_use[i]) + 64'(blac_pkg::GRACE_FRAMES)
                               <= 64'(frame_now)
                            && (best < 0 || ent_last_use[i] < ent_last_use[best])) begin
                            best = i;
                        end
                    end
                    if (best < 0) begin
                        break;
                    end
                    freed           = ent_size[best];
                    ent_valid[best] = 1'b0;
                    resident_bytes  = (resident_bytes >= 40'(freed)) ?
                                      resident_bytes - 40'(freed) : '0;
                    add_reply(blac_pkg::KIND_EVICT, blac_pkg::ST_MISSING, 1'b0, ent_key[best],
                              freed, 1'b0);
                    evicted++;
                end
                add_reply(blac_pkg::KIND_DONE, blac_pkg::ST_MISSING, 1'b0, '0, '0, 1'b1);
            end
        endcase
    endtask

    // Random item: mostly request/complete lifecycles on a key pool, plus frames and settles.
    function automatic t_cache_op pick_random_op();
        t_cache_op op;
        int        loading [$];
        int        roll;
        op.hash  = $urandom();
        op.pkg   = 1'($urandom_range(0, 1));
        op.ok    = 1'($urandom_range(0, 1));
        op.bytes = $urandom();
        for (int i = 0; i < N_ENT; i++) begin
            if (ent_valid[i] && ent_state[i] == blac_pkg::ST_LOADING) begin
                loading.insert(loading.size(), i);
            end
        end
        roll = $urandom_range(0, 99);
        if (roll < 38) begin
            op.func = blac_pkg::FUNC_LOOKUP;
            roll    = $urandom_range(0, 99);
            if (roll < 4) begin
                op.hash = '0;
            end else if (roll >= 8) begin
                op.hash = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            end
            op.pkg = ($urandom_range(0, 99) < 85);
        end else if (roll < 63) begin
            op.func = blac_pkg::FUNC_COMPLETE;
            if (loading.size() > 0 && $urandom_range(0, 99) < 85) begin
                op.hash = ent_key[loading[$urandom_range(0, loading.size() - 1)]];
            end else if ($urandom_range(0, 1) == 1) begin
                op.hash = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            end
            op.ok = ($urandom_range(0, 99) < 85);
            roll  = $urandom_range(0, 99);
            if (roll < 70) begin
                op.bytes = $urandom_range(0, 32'h0030_0000);
            end else if (roll < 80) begin
                op.bytes = '0;
            end else if (roll < 85) begin
                op.bytes = 32'hFFFF_FFFF;
            end
        end else if (roll < 83) begin
            op.func = blac_pkg::FUNC_NEWFRAME;
        end else begin
            op.func = blac_pkg::FUNC_SETTLE;
        end
        return op;
    endfunction

    // Offers one item, with random gaps before it, and records its replies once accepted.
    task automatic offer_item(input t_cache_op op, input logic typed,
                              input t_cache_result want);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        in_valid    <= 1'b1;
        func        <= op.func;
        asset_hash  <= op.hash;
        in_package  <= op.pkg;
        load_ok     <= op.ok;
        asset_bytes <= op.bytes;
        do @(posedge clk); while (in_stall);
        predict_cache_replies(op);
        if (typed) begin
            replies_due.insert(replies_due.size(), want);
        end else begin
            foreach (item_replies[k]) begin
                replies_due.insert(replies_due.size(), item_replies[k]);
            end
        end
    endtask

    // Lets the block go idle, then writes the budget register.
    task automatic drain_then_set_budget(input logic [11:0] value);
        in_valid <= 1'b0;
        while (replies_due.size() != 0) begin
            @(posedge clk);
        end
        cfg_valid     <= 1'b1;
        cfg_budget_mb <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        budget_now  = value;
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // Result checker: each transfer is compared with the oldest predicted reply.
    always @(posedge clk) begin
        t_cache_result want;
        if (rst_n && out_valid && !out_stall) begin
            reply_count++;
            if (replies_due.size() == 0) begin
                note_mismatch($sformatf("reply %0d arrived with none expected", reply_count));
            end else begin
                want = replies_due.pop_front();
                if (res_kind !== want.kind)
                    note_mismatch($sformatf("reply %0d kind %0d, want %0d",
                                            reply_count, res_kind, want.kind));
                if (res_status !== want.status)
                    note_mismatch($sformatf("reply %0d status %0d, want %0d",
                                            reply_count, res_status, want.status));
                if (res_req !== want.req)
                    note_mismatch($sformatf("reply %0d request_load %0b, want %0b",
                                            reply_count, res_req, want.req));
                if (res_evicted_hash !== want.hash)
                    note_mismatch($sformatf("reply %0d evicted_hash %h, want %h",
                                            reply_count, res_evicted_hash, want.hash));
                if (res_freed !== want.freed)
                    note_mismatch($sformatf("reply %0d freed_bytes %h, want %h",
                                            reply_count, res_freed, want.freed));
                if (res_total !== want.total)
                    note_mismatch($sformatf("reply %0d total_resident %h, want %h",
                                            reply_count, res_total, want.total));
                if (res_last !== want.last)
                    note_mismatch($sformatf("reply %0d last %0b, want %0b",
                                            reply_count, res_last, want.last));
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_cache_op   op;
        logic [11:0] phase_budget;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_budget_mb = '0;
        in_valid      = 1'b0;
        func          = blac_pkg::FUNC_LOOKUP;
        asset_hash    = '0;
        in_package    = 1'b0;
        load_ok       = 1'b0;
        asset_bytes   = '0;
        out_stall     = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_left     = 0;
        hold_request  = 1'b0;
        error_count   = 0;
        reply_count   = 0;
        quiet_cycles  = 0;
        frame_now      = '0;
        resident_bytes = '0;
        budget_now     = '0;
        foreach (ent_valid[i]) begin
            ent_valid[i]    = 1'b0;
            ent_key[i]      = '0;
            ent_state[i]    = blac_pkg::ST_MISSING;
            ent_last_use[i] = '0;
            ent_size[i]     = '0;
        end
        // The pool is larger than the table so that it fills up and answers table full.
        foreach (key_pool[i]) begin
            key_pool[i] = $urandom();
            if (key_pool[i] == '0) begin
                key_pool[i] = 32'h1;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, with budget writes where a row asks for one.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].cfg_first) begin
                drain_then_set_budget(directed_rows[r].cfg_value);
            end
            offer_item(directed_rows[r].op, directed_rows[r].typed, directed_rows[r].want);
        end

        // Random traffic in four idling phases, each under its own budget.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    phase_budget = 12'd1;
                end
                1: begin
                    tx_idle_pct  = 62;
                    rx_stall_pct = 0;
                    phase_budget = 12'd0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 62;
                    phase_budget = 12'($urandom_range(2, 8));
                end
                default: begin
                    tx_idle_pct  = 17;
                    rx_stall_pct = 17;
                    phase_budget = 12'($urandom_range(1, 16));
                end
            endcase
            drain_then_set_budget(phase_budget);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Long receiver hold-off while items keep coming, so the input backs up.
                if (phase == 0 && k == 12) begin
                    hold_request = 1'b1;
                end
                op = pick_random_op();
                offer_item(op, 1'b0, UNTYPED);
            end
        end

        in_valid <= 1'b0;
        while (replies_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (2 * ITEM_LATENCY) @(posedge clk);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/blac_pkg.sv
rtl/core/budgeted_lru_asset_cache.sv
dv/tb_budgeted_lru_asset_cache.sv
